// ===== rtl/ordered_event_reorder_buffer_macros.svh =====
// ----------------------------------------------------------------------------
// ordered event reorder buffer assertion macros
// shared property forms for the checks at the end of oerb_back
// ----------------------------------------------------------------------------
`ifndef ORDERED_EVENT_REORDER_BUFFER_MACROS_SVH
`define ORDERED_EVENT_REORDER_BUFFER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define OERB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define OERB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/oerb_pkg.sv =====
// ----------------------------------------------------------------------------
// oerb_pkg
// shared constants and types of the ordered event reorder buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package oerb_pkg;

    // sequence space is fixed by the 7-bit header field
    localparam int SEQ_BITS     = 7;
    localparam int SEQ_SPACE    = 1 << SEQ_BITS;
    localparam int SEQ_OUT_BITS = 8;

    localparam logic [SEQ_BITS-1:0]     PREV_START = SEQ_BITS'(SEQ_SPACE - 4);
    localparam logic [SEQ_BITS-1:0]     PREV_UNORD = SEQ_BITS'(SEQ_SPACE - 2);
    localparam logic [SEQ_OUT_BITS-1:0] NO_SEQ     = SEQ_OUT_BITS'(SEQ_SPACE);

    // sequence mode codes
    localparam logic [1:0] SEQ_IMPLICIT  = 2'd0;
    localparam logic [1:0] SEQ_UNORDERED = 2'd1;
    localparam logic [1:0] SEQ_EXPLICIT  = 2'd2;

    // result status codes
    localparam logic STATUS_DELIVERED = 1'b0;
    localparam logic STATUS_DROPPED   = 1'b1;

    typedef struct packed {
        logic                ordered;
        logic [SEQ_BITS-1:0] seq;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/oerb_if.sv =====
// ----------------------------------------------------------------------------
// oerb_in_if / oerb_out_if
// valid/ready channels for event headers and delivery results
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface oerb_in_if #(
    parameter int TAG_BITS = 16
) ();
    logic                              valid;
    logic                              ready;
    logic                              packet_start;
    logic                              guaranteed;
    logic [1:0]                        seq_mode;
    logic [oerb_pkg::SEQ_BITS-1:0]     explicit_seq;
    logic [TAG_BITS-1:0]               event_tag;

    modport source (
        output valid, packet_start, guaranteed, seq_mode, explicit_seq, event_tag,
        input  ready
    );
    modport sink (
        input  valid, packet_start, guaranteed, seq_mode, explicit_seq, event_tag,
        output ready
    );
endinterface

interface oerb_out_if #(
    parameter int TAG_BITS = 16
) ();
    logic                              valid;
    logic                              ready;
    logic [TAG_BITS-1:0]               out_tag;
    logic [oerb_pkg::SEQ_OUT_BITS-1:0] out_seq;
    logic                              status;
    logic                              last;

    modport source (
        output valid, out_tag, out_seq, status, last,
        input  ready
    );
    modport sink (
        input  valid, out_tag, out_seq, status, last,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/ordered_event_reorder_buffer.sv =====
// ----------------------------------------------------------------------------
// ordered_event_reorder_buffer
// an accepted header is written to the queue; its result then enters the output register
// throughput: one header per cycle while the queue has room and the output is not stalled
// release runs at one event per cycle unless the output stalls, set by the single tag read port
// reset: synchronous active low; clears counters, expected number and all 128 slot valid bits
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ordered_event_reorder_buffer #(
    parameter int TAG_BITS   = 16,
    parameter int WAIT_LIMIT = 63
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    oerb_in_if.sink    i_evt,
    oerb_out_if.source o_res
);

    localparam int Q_W = $bits(oerb_pkg::t_cmd) + TAG_BITS;

    logic                 push;
    logic                 pop;
    oerb_pkg::t_cmd       f_cmd;
    logic [TAG_BITS-1:0]  f_tag;
    oerb_pkg::t_cmd       b_cmd;
    logic [TAG_BITS-1:0]  b_tag;
    logic [Q_W-1:0]       q_out;
    oerb_pkg::t_q_status  q_status;

    oerb_front #(
        .TAG_BITS (TAG_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_evt      (i_evt),
        .i_q_status (q_status),
        .o_push     (push),
        .o_cmd      (f_cmd),
        .o_tag      (f_tag)
    );

    oerb_queue #(
        .W (Q_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data ({f_cmd, f_tag}),
        .i_pop       (pop),
        .o_pop_data  (q_out),
        .o_status    (q_status)
    );

    assign {b_cmd, b_tag} = q_out;

    oerb_back #(
        .TAG_BITS   (TAG_BITS),
        .WAIT_LIMIT (WAIT_LIMIT)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_cmd      (b_cmd),
        .i_tag      (b_tag),
        .o_pop      (pop),
        .o_res      (o_res)
    );

endmodule

`default_nettype wire

// ===== rtl/oerb_front.sv =====
// ----------------------------------------------------------------------------
// oerb_front
// accepts event headers, resolves the sequence number and classifies them
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oerb_front #(
    parameter int TAG_BITS = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    oerb_in_if.sink                   i_evt,
    input  wire oerb_pkg::t_q_status  i_q_status,
    output logic                      o_push,
    output oerb_pkg::t_cmd            o_cmd,
    output logic [TAG_BITS-1:0]       o_tag
);

    logic [oerb_pkg::SEQ_BITS-1:0] r_prev_seq;
    logic [oerb_pkg::SEQ_BITS-1:0] n_prev_seq;
    logic [oerb_pkg::SEQ_BITS-1:0] prev_base;

    assign i_evt.ready = !i_q_status.full;
    assign o_push      = i_evt.valid && !i_q_status.full;
    assign o_tag       = i_evt.event_tag;

    always_comb begin
        prev_base   = i_evt.packet_start ? oerb_pkg::PREV_START : r_prev_seq;
        n_prev_seq  = prev_base;
        o_cmd.ordered = 1'b0;
        o_cmd.seq     = prev_base + 1'b1;
        if (i_evt.guaranteed) begin
            unique case (i_evt.seq_mode)
                oerb_pkg::SEQ_IMPLICIT: begin
                    o_cmd.ordered = 1'b1;
                    n_prev_seq    = o_cmd.seq;
                end
                oerb_pkg::SEQ_EXPLICIT: begin
                    o_cmd.ordered = 1'b1;
                    o_cmd.seq     = i_evt.explicit_seq;
                    n_prev_seq    = i_evt.explicit_seq;
                end
                // unordered, and the unused code
                default: begin
                    n_prev_seq = oerb_pkg::PREV_UNORD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_seq <= oerb_pkg::PREV_START;
        end else if (o_push) begin
            r_prev_seq <= n_prev_seq;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/oerb_queue.sv =====
// ----------------------------------------------------------------------------
// oerb_queue
// two-entry queue of classified words between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module oerb_queue #(
    parameter int W = 24
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_push,
    input  wire logic [W-1:0]         i_push_data,
    input  wire logic                 i_pop,
    output logic [W-1:0]              o_pop_data,
    output oerb_pkg::t_q_status       o_status
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_pop_data     = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/oerb_back.sv =====
// ----------------------------------------------------------------------------
// oerb_back
// slot store, in-order release sequencer and result output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ordered_event_reorder_buffer_macros.svh"

module oerb_back #(
    parameter int TAG_BITS   = 16,
    parameter int WAIT_LIMIT = 63
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire oerb_pkg::t_q_status  i_q_status,
    input  wire oerb_pkg::t_cmd       i_cmd,
    input  wire logic [TAG_BITS-1:0]  i_tag,
    output logic                      o_pop,
    oerb_out_if.source                o_res
);

    localparam int CNT_W = $clog2(WAIT_LIMIT + 1);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } t_back_state;

    t_back_state                       r_state, n_state;
    logic [oerb_pkg::SEQ_BITS-1:0]     r_expected, n_expected, exp_nx;
    logic [CNT_W-1:0]                  r_wait_cnt, n_wait_cnt;
    logic [oerb_pkg::SEQ_SPACE-1:0]    r_slot_valid;
    logic [TAG_BITS-1:0]               r_slot_tag [oerb_pkg::SEQ_SPACE];
    logic [TAG_BITS-1:0]               r_rd_data;

    logic                              r_out_valid;
    logic [TAG_BITS-1:0]               r_out_tag;
    logic [oerb_pkg::SEQ_OUT_BITS-1:0] r_out_seq;
    logic                              r_out_status;
    logic                              r_out_last;

    logic                              can_put;
    logic                              emit;
    logic [TAG_BITS-1:0]               e_tag;
    logic [oerb_pkg::SEQ_OUT_BITS-1:0] e_seq;
    logic                              e_status;
    logic                              e_last;
    logic                              mem_we;
    logic                              set_valid;
    logic                              clr_valid;

    assign can_put = !r_out_valid || o_res.ready;
    assign exp_nx  = r_expected + 1'b1;

    always_comb begin
        n_state    = r_state;
        n_expected = r_expected;
        n_wait_cnt = r_wait_cnt;
        o_pop      = 1'b0;
        emit       = 1'b0;
        e_tag      = i_tag;
        e_seq      = '0;
        e_seq[oerb_pkg::SEQ_BITS-1:0] = i_cmd.seq;
        e_status   = oerb_pkg::STATUS_DELIVERED;
        e_last     = 1'b1;
        mem_we     = 1'b0;
        set_valid  = 1'b0;
        clr_valid  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_status.empty) begin
                    if (!i_cmd.ordered) begin
                        if (can_put) begin
                            emit  = 1'b1;
                            e_seq = oerb_pkg::NO_SEQ;
                            o_pop = 1'b1;
                        end
                    end else if (i_cmd.seq != r_expected) begin
                        if (r_slot_valid[i_cmd.seq]) begin
                            // duplicate number: newest tag wins
                            mem_we = 1'b1;
                            o_pop  = 1'b1;
                        end else if (r_wait_cnt >= CNT_W'(WAIT_LIMIT)) begin
                            if (can_put) begin
                                emit     = 1'b1;
                                e_status = oerb_pkg::STATUS_DROPPED;
                                o_pop    = 1'b1;
                            end
                        end else begin
                            mem_we     = 1'b1;
                            set_valid  = 1'b1;
                            n_wait_cnt = r_wait_cnt + 1'b1;
                            o_pop      = 1'b1;
                        end
                    end else if (can_put) begin
                        emit       = 1'b1;
                        e_last     = !r_slot_valid[exp_nx];
                        n_expected = exp_nx;
                        o_pop      = 1'b1;
                        if (r_slot_valid[exp_nx]) begin
                            n_state = S_SEND;
                        end
                    end
                end
            end
            S_SEND: begin
                // read data was registered from the slot that n_expected addressed in the previous cycle
                if (can_put) begin
                    emit       = 1'b1;
                    e_tag      = r_rd_data;
                    e_seq      = '0;
                    e_seq[oerb_pkg::SEQ_BITS-1:0] = r_expected;
                    e_last     = !r_slot_valid[exp_nx];
                    clr_valid  = 1'b1;
                    n_wait_cnt = r_wait_cnt - 1'b1;
                    n_expected = exp_nx;
                    if (!r_slot_valid[exp_nx]) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // tag store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_slot_tag[i_cmd.seq] <= i_tag;
        end
        r_rd_data <= r_slot_tag[n_expected];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_expected   <= '0;
            r_wait_cnt   <= '0;
            r_slot_valid <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_expected <= n_expected;
            r_wait_cnt <= n_wait_cnt;
            if (set_valid) begin
                r_slot_valid[i_cmd.seq] <= 1'b1;
            end
            if (clr_valid) begin
                r_slot_valid[r_expected] <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_tag    <= e_tag;
            r_out_seq    <= e_seq;
            r_out_status <= e_status;
            r_out_last   <= e_last;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.out_tag = r_out_tag;
    assign o_res.out_seq = r_out_seq;
    assign o_res.status  = r_out_status;
    assign o_res.last    = r_out_last;

    `OERB_ASSERT_IMPL(a_wait_bound, i_clk, i_rst_n, 1'b1, r_wait_cnt <= CNT_W'(WAIT_LIMIT), "waiting count above limit")
    `OERB_ASSERT_IMPL(a_count_match, i_clk, i_rst_n, 1'b1, $countones(r_slot_valid) == int'(r_wait_cnt), "valid slots disagree with waiting count")
    `OERB_ASSERT_IMPL(a_idle_expected_empty, i_clk, i_rst_n, r_state == S_IDLE, !r_slot_valid[r_expected], "expected slot parked while idle")
    `OERB_ASSERT_NEXT(a_release_advance, i_clk, i_rst_n, r_state == S_SEND && can_put, r_expected == $past(exp_nx), "release did not advance expected number")

endmodule

`default_nettype wire
